@@ rtl/ole_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine package
// Operation codes, sequencer states and fixed field widths of the list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int KIND_W = 3;
	localparam int POS_W  = 6;
	localparam int DATA_W = 32;
	localparam int FPOS_W = 5;
	localparam int LEN_W  = 6;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 3'd0,
		KIND_REMOVE = 3'd1,
		KIND_SET    = 3'd2,
		KIND_GET    = 3'd3,
		KIND_FIND   = 3'd4,
		KIND_CLEAR  = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT_UP,
		ST_INS_FINAL,
		ST_SHIFT_DN,
		ST_GET_WAIT,
		ST_FINDING
	} state_t;

endpackage

@@ rtl/ole_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface ole_op_if import ole_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] data_value;

	modport source (output valid, kind, position, data_value, input ready);
	modport sink (input valid, kind, position, data_value, output ready);
endinterface

interface ole_res_if import ole_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              ok;
	logic [DATA_W-1:0] read_value;
	logic              found;
	logic [FPOS_W-1:0] found_position;
	logic [LEN_W-1:0]  list_length;

	modport source (output valid, ok, read_value, found, found_position, list_length,
		input ready);
	modport sink (input valid, ok, read_value, found, found_position, list_length,
		output ready);
endinterface

@@ rtl/ole_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/ordered_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine
// Ordered list of words with insert, remove, set, get, find and clear.
// ----------------------------------------------------------------------------
// The list lives in one RAM of CAPACITY words with a single write port and a
// registered read port, and the engine works on one item at a time. Set, clear,
// rejected operations and an insert at the end of the list finish in the cycle
// in which they are taken; get waits for the registered read. Insert inside the
// list and remove read each later entry and write it back one place over, one
// entry per cycle through the RAM ports; the final write of either waits while
// the output register is busy. Find reads entries in order from the front until
// a match or the end of the list. The result item appears in an output
// register the cycle after the operation finishes; the next item is taken while
// that result still waits, as long as the output register is free or being
// emptied in the same cycle. Entries are not cleared at reset: only the length
// is, and every read stays below the length.
module ordered_list_engine
	import ole_pkg::*;
#(
	parameter int CAPACITY   = 32,
	parameter int ELEM_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	ole_op_if.sink    op,
	ole_res_if.source res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	// Common width for comparing positions against the length.
	localparam int KW = (CW > POS_W) ? CW : POS_W;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] raddr_s1;
	logic [AW-1:0] pos_q;
	logic [ELEM_WIDTH-1:0] val_q;

	logic [AW-1:0] ram_raddr;
	logic [ELEM_WIDTH-1:0] ram_rdata;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [ELEM_WIDTH-1:0] ram_wdata;

	logic res_valid_q;
	logic res_ok_q, res_found_q;
	logic [DATA_W-1:0] res_rd_q;
	logic [FPOS_W-1:0] res_fpos_q;
	logic [LEN_W-1:0] res_len_q;

	logic res_load, res_ok_d, res_found_d;
	logic [DATA_W-1:0] res_rd_d;
	logic [FPOS_W-1:0] res_fpos_d;

	logic out_free, in_ready, in_fire;
	logic [KW-1:0] pos_k, cnt_k, len_k, fpos_k;
	logic [AW-1:0] pos_a, last_a;
	logic [63:0] val_wide, rd_wide;
	logic [ELEM_WIDTH-1:0] val_in;

	// The output register can take a new result when it is empty or being read.
	assign out_free = !res_valid_q || res.ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_fire  = op.valid && in_ready;
	assign op.ready = in_ready;

	assign pos_k    = KW'(op.position);
	assign cnt_k    = KW'(count_q);
	assign pos_a    = pos_k[AW-1:0];
	assign last_a   = AW'(cnt_k - KW'(1));
	assign val_wide = 64'(op.data_value);
	assign val_in   = val_wide[ELEM_WIDTH-1:0];
	assign rd_wide  = 64'(ram_rdata);
	assign fpos_k   = KW'(raddr_s1);

	ole_ram #(
		.WIDTH(ELEM_WIDTH),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// The read data always belongs to the address presented the cycle before.
	always_ff @(posedge clk) begin
		raddr_s1 <= ram_raddr;
		if (in_fire) begin
			pos_q <= pos_a;
			val_q <= val_in;
		end
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		ram_raddr   = raddr_s1;
		ram_we      = 1'b0;
		ram_waddr   = pos_a;
		ram_wdata   = val_in;
		res_load    = 1'b0;
		res_ok_d    = 1'b0;
		res_rd_d    = '0;
		res_found_d = 1'b0;
		res_fpos_d  = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					res_load = 1'b1;
					case (kind_t'(op.kind))
						KIND_INSERT: begin
							if (cnt_k < KW'(CAPACITY) && pos_k <= cnt_k) begin
								if (pos_k == cnt_k) begin
									// Append: nothing moves.
									ram_we   = 1'b1;
									count_d  = count_q + CW'(1);
									res_ok_d = 1'b1;
								end else begin
									res_load  = 1'b0;
									ram_raddr = last_a;
									state_d   = ST_SHIFT_UP;
								end
							end
						end
						KIND_REMOVE: begin
							if (pos_k < cnt_k) begin
								if (pos_a == last_a) begin
									count_d  = count_q - CW'(1);
									res_ok_d = 1'b1;
								end else begin
									res_load  = 1'b0;
									ram_raddr = pos_a + AW'(1);
									state_d   = ST_SHIFT_DN;
								end
							end
						end
						KIND_SET: begin
							if (pos_k < cnt_k) begin
								ram_we   = 1'b1;
								res_ok_d = 1'b1;
							end
						end
						KIND_GET: begin
							if (pos_k < cnt_k) begin
								res_load  = 1'b0;
								ram_raddr = pos_a;
								state_d   = ST_GET_WAIT;
							end
						end
						KIND_FIND: begin
							if (count_q != '0) begin
								res_load  = 1'b0;
								ram_raddr = '0;
								state_d   = ST_FINDING;
							end
						end
						KIND_CLEAR: begin
							count_d  = '0;
							res_ok_d = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SHIFT_UP: begin
				// Move the entry just read one place up, then read the one below.
				ram_we    = 1'b1;
				ram_waddr = raddr_s1 + AW'(1);
				ram_wdata = ram_rdata;
				if (raddr_s1 == pos_q) begin
					state_d = ST_INS_FINAL;
				end else begin
					ram_raddr = raddr_s1 - AW'(1);
				end
			end
			ST_INS_FINAL: begin
				if (out_free) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = val_q;
					count_d   = count_q + CW'(1);
					res_load  = 1'b1;
					res_ok_d  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_SHIFT_DN: begin
				// Move the entry just read one place down, then read the one above.
				// On the last entry a busy output holds everything, and the read
				// of the same address repeats.
				ram_waddr = raddr_s1 - AW'(1);
				ram_wdata = ram_rdata;
				if (raddr_s1 == last_a) begin
					if (out_free) begin
						ram_we   = 1'b1;
						count_d  = count_q - CW'(1);
						res_load = 1'b1;
						res_ok_d = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					ram_we    = 1'b1;
					ram_raddr = raddr_s1 + AW'(1);
				end
			end
			ST_GET_WAIT: begin
				if (out_free) begin
					res_load = 1'b1;
					res_ok_d = 1'b1;
					res_rd_d = rd_wide[DATA_W-1:0];
					state_d  = ST_IDLE;
				end
			end
			ST_FINDING: begin
				if (ram_rdata == val_q) begin
					if (out_free) begin
						res_load    = 1'b1;
						res_ok_d    = 1'b1;
						res_found_d = 1'b1;
						res_fpos_d  = fpos_k[FPOS_W-1:0];
						state_d     = ST_IDLE;
					end
				end else if (raddr_s1 == last_a) begin
					if (out_free) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					ram_raddr = raddr_s1 + AW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign len_k = KW'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_ok_q    <= res_ok_d;
			res_rd_q    <= res_rd_d;
			res_found_q <= res_found_d;
			res_fpos_q  <= res_fpos_d;
			res_len_q   <= len_k[LEN_W-1:0];
		end
	end

	assign res.valid          = res_valid_q;
	assign res.ok             = res_ok_q;
	assign res.read_value     = res_rd_q;
	assign res.found          = res_found_q;
	assign res.found_position = res_fpos_q;
	assign res.list_length    = res_len_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length exceeds capacity");

	a_shift_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT_UP || state_q == ST_SHIFT_DN) && ram_we
		|-> ram_waddr != ram_raddr)
		else $error("shift writes the entry it reads");

	a_count_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!res_load |=> $stable(count_q))
		else $error("length changed without a result");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_found_q |-> res_ok_q)
		else $error("find match reported as failure");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result loaded over a waiting result");
`endif

endmodule
